@@ sv/cpg_pkg.sv @@
// ---------------------------------------------------------------------------
// cpg_pkg: shared types and constants for the control pickup gate
// Slot geometry, function codes and the command word passed front to back.
// ---------------------------------------------------------------------------
package cpg_pkg;

    localparam int NUM_DECKS     = 2;
    localparam int DECK_CONTROLS = 8;
    localparam int VALUE_BITS    = 17;
    localparam int TOL_BITS      = 16;
    localparam int NUM_SLOTS     = NUM_DECKS * DECK_CONTROLS + 1;
    localparam int SLOT_W        = $clog2(NUM_SLOTS);
    localparam int COUNT_W       = $clog2(NUM_SLOTS + 1);
    localparam int DIFF_W        = (VALUE_BITS > TOL_BITS) ? VALUE_BITS : TOL_BITS;

    localparam logic [3:0] TEMPO_ID      = 4'd0;
    localparam logic [3:0] CROSSFADER_ID = 4'd8;
    localparam logic [2:0] NO_DECK       = 3'b111;

    localparam logic [TOL_BITS-1:0] TEMPO_TOL_RESET = TOL_BITS'(66);
    localparam logic [TOL_BITS-1:0] MIXER_TOL_RESET = TOL_BITS'(786);

    // configuration register indexes
    localparam logic CFG_TEMPO_TOL = 1'b0;
    localparam logic CFG_MIXER_TOL = 1'b1;

    typedef enum logic [2:0] {
        FUNC_MOVE      = 3'd0,
        FUNC_REMEMBER  = 3'd1,
        FUNC_CLEAR_TGT = 3'd2,
        FUNC_ARM       = 3'd3,
        FUNC_RETARGET  = 3'd4,
        FUNC_CLEAR_ALL = 3'd5
    } func_t;

    // decoded command word, front to back
    typedef struct packed {
        logic [2:0]            func;
        logic                  slot_ok;
        logic [SLOT_W-1:0]     slot;
        logic [TOL_BITS-1:0]   tol;
        logic [VALUE_BITS-1:0] value;
    } cmd_t;

endpackage

@@ sv/cpg_front.sv @@
// ---------------------------------------------------------------------------
// cpg_front: input decode stage
// Holds the tolerance registers, maps control/deck to a slot and pushes
// one decoded command word into the queue.
// ---------------------------------------------------------------------------
module cpg_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     func,
    input  logic [3:0]                     control_id,
    input  logic signed [2:0]              deck_index,
    input  logic [cpg_pkg::VALUE_BITS-1:0] control_value,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [cpg_pkg::TOL_BITS-1:0]   cfg_data,
    input  logic                           q_full,
    output logic                           push,
    output cpg_pkg::cmd_t                  push_word
);

    logic [cpg_pkg::TOL_BITS-1:0] tempo_tol_reg;
    logic [cpg_pkg::TOL_BITS-1:0] mixer_tol_reg;
    logic                         stage_valid_reg;
    cpg_pkg::cmd_t                stage_reg;
    cpg_pkg::cmd_t                dec;
    logic                         take;
    logic                         deck_in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_tol_reg <= cpg_pkg::TEMPO_TOL_RESET;
            mixer_tol_reg <= cpg_pkg::MIXER_TOL_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == cpg_pkg::CFG_TEMPO_TOL)
                tempo_tol_reg <= cfg_data;
            else
                mixer_tol_reg <= cfg_data;
        end
    end

    // slot decode: crossfader only without deck, deck controls need a real deck
    always_comb
    begin
        deck_in_range = !deck_index[2] &&
                        (int'(deck_index[1:0]) < cpg_pkg::NUM_DECKS);
        dec.func  = func;
        dec.value = control_value;
        dec.tol   = (control_id == cpg_pkg::TEMPO_ID) ? tempo_tol_reg : mixer_tol_reg;
        if (control_id == cpg_pkg::CROSSFADER_ID)
        begin
            dec.slot_ok = (deck_index == cpg_pkg::NO_DECK);
            dec.slot    = cpg_pkg::SLOT_W'(cpg_pkg::NUM_DECKS * cpg_pkg::DECK_CONTROLS);
        end
        else
        begin
            dec.slot_ok = deck_in_range && (int'(control_id) < cpg_pkg::DECK_CONTROLS);
            dec.slot    = cpg_pkg::SLOT_W'(int'(deck_index[1:0]) * cpg_pkg::DECK_CONTROLS
                                           + int'(control_id));
        end
    end

    assign push      = stage_valid_reg && !q_full;
    assign busy      = stage_valid_reg && q_full;
    assign take      = start && !busy;
    assign push_word = stage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (take)
            stage_valid_reg <= 1'b1;
        else if (push)
            stage_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            stage_reg <= dec;
    end

endmodule

@@ sv/cpg_queue.sv @@
// ---------------------------------------------------------------------------
// cpg_queue: two-entry command queue
// Decouples the decode stage from the slot table update.
// ---------------------------------------------------------------------------
module cpg_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cpg_pkg::cmd_t push_word,
    input  logic          pop,
    output cpg_pkg::cmd_t pop_word,
    output logic          full,
    output logic          empty
);

    cpg_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    fill_reg;
    logic          do_push;
    logic          do_pop;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_word = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 2'd1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_word;
    end

endmodule

@@ sv/cpg_back.sv @@
// ---------------------------------------------------------------------------
// cpg_back: slot table and result stage
// One read-modify-write of the slot table per command; result registered.
// ---------------------------------------------------------------------------
module cpg_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    input  cpg_pkg::cmd_t                cmd,
    output logic                         done,
    output logic                         accepted,
    output logic                         state_changed,
    output logic                         retarget_notice,
    output logic                         pickup_active,
    output logic [cpg_pkg::COUNT_W-1:0]  pending_count
);

    logic [cpg_pkg::VALUE_BITS-1:0] hw_value_reg     [cpg_pkg::NUM_SLOTS];
    logic [cpg_pkg::VALUE_BITS-1:0] target_value_reg [cpg_pkg::NUM_SLOTS];
    logic [cpg_pkg::NUM_SLOTS-1:0]  known_reg;
    logic [cpg_pkg::NUM_SLOTS-1:0]  pend_reg;
    logic [cpg_pkg::COUNT_W-1:0]    count_reg;
    logic [cpg_pkg::COUNT_W-1:0]    count_next;

    logic                           done_reg;
    logic                           accepted_reg;
    logic                           changed_reg;
    logic                           notice_reg;

    logic [cpg_pkg::VALUE_BITS-1:0] hw_s;
    logic [cpg_pkg::VALUE_BITS-1:0] tgt_s;
    logic                           known_s;
    logic                           pend_s;
    logic [cpg_pkg::VALUE_BITS-1:0] ref_v;
    logic [cpg_pkg::VALUE_BITS-1:0] diff;
    logic                           near;
    logic                           keep;

    logic hw_we, tgt_we, pend_we, pend_val, pend_clr, known_clr;
    logic acc_c, chg_c, notice_c;

    assign hw_s    = hw_value_reg[cmd.slot];
    assign tgt_s   = target_value_reg[cmd.slot];
    assign known_s = known_reg[cmd.slot];
    assign pend_s  = pend_reg[cmd.slot];

    // one distance check: a move compares with the target, arm/retarget with hw
    assign ref_v = (cmd.func == cpg_pkg::FUNC_MOVE) ? tgt_s : hw_s;
    assign diff  = (cmd.value >= ref_v) ? (cmd.value - ref_v) : (ref_v - cmd.value);
    assign near  = (cpg_pkg::DIFF_W'(diff) <= cpg_pkg::DIFF_W'(cmd.tol));
    assign keep  = !(known_s && near);

    always_comb
    begin
        hw_we      = 1'b0;
        tgt_we     = 1'b0;
        pend_we    = 1'b0;
        pend_val   = 1'b0;
        pend_clr   = 1'b0;
        known_clr  = 1'b0;
        acc_c      = 1'b0;
        chg_c      = 1'b0;
        notice_c   = 1'b0;
        count_next = count_reg;
        case (cpg_pkg::func_t'(cmd.func))
            cpg_pkg::FUNC_MOVE:
            begin
                acc_c = 1'b1;
                if (cmd.slot_ok)
                begin
                    hw_we = 1'b1;
                    if (pend_s)
                    begin
                        chg_c = 1'b1;
                        acc_c = 1'b0;
                        if (near)
                        begin
                            pend_we    = 1'b1;
                            count_next = count_reg - cpg_pkg::COUNT_W'(1);
                        end
                    end
                end
            end
            cpg_pkg::FUNC_REMEMBER:
                hw_we = cmd.slot_ok;
            cpg_pkg::FUNC_CLEAR_TGT:
            begin
                pend_clr   = 1'b1;
                count_next = '0;
            end
            cpg_pkg::FUNC_ARM:
            begin
                if (cmd.slot_ok && keep)
                begin
                    tgt_we   = 1'b1;
                    pend_we  = 1'b1;
                    pend_val = 1'b1;
                    if (!pend_s)
                        count_next = count_reg + cpg_pkg::COUNT_W'(1);
                end
            end
            cpg_pkg::FUNC_RETARGET:
            begin
                if (cmd.slot_ok)
                begin
                    tgt_we     = 1'b1;
                    pend_we    = 1'b1;
                    pend_val   = keep;
                    count_next = count_reg - cpg_pkg::COUNT_W'(pend_s)
                                 + cpg_pkg::COUNT_W'(keep);
                    notice_c   = !pend_s || (tgt_s != cmd.value) || (count_next == '0);
                end
            end
            cpg_pkg::FUNC_CLEAR_ALL:
            begin
                pend_clr   = 1'b1;
                known_clr  = 1'b1;
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_reg    <= '0;
            pend_reg     <= '0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            accepted_reg <= 1'b0;
            changed_reg  <= 1'b0;
            notice_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= cmd_valid;
            if (cmd_valid)
            begin
                count_reg    <= count_next;
                accepted_reg <= acc_c;
                changed_reg  <= chg_c;
                notice_reg   <= notice_c;
                if (known_clr)
                    known_reg <= '0;
                else if (hw_we)
                    known_reg[cmd.slot] <= 1'b1;
                if (pend_clr)
                    pend_reg <= '0;
                else if (pend_we)
                    pend_reg[cmd.slot] <= pend_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && hw_we)
            hw_value_reg[cmd.slot] <= cmd.value;
        if (cmd_valid && tgt_we)
            target_value_reg[cmd.slot] <= cmd.value;
    end

    assign done            = done_reg;
    assign accepted        = accepted_reg;
    assign state_changed   = changed_reg;
    assign retarget_notice = notice_reg;
    assign pending_count   = count_reg;
    assign pickup_active   = (count_reg != '0);

endmodule

@@ sv/control_pickup_gate_core.sv @@
// ---------------------------------------------------------------------------
// control_pickup_gate_core: soft-takeover gate for absolute controller knobs
// Decode front, two-word queue, slot table back end.
// ---------------------------------------------------------------------------
// A word is taken on a clock edge with start high and busy low. Each word
// yields exactly one result, shown for one cycle with done high, after it
// passes the decode register, the queue and the slot table update.
// The receiver cannot stall: the back end retires one word per cycle, so
// busy stays low in normal use and a new word may be issued every cycle;
// sustained rate is one word per clock, set by the single read-modify-write
// of the 17-slot table. Slots 0..15 are deck*8+control, slot 16 is the
// crossfader (control 8 with deck -1). Unsupported control/deck pairs pass
// moves through and leave the table alone. The user must write tolerances
// through cfg_we/cfg_index/cfg_data (0 tempo, 1 mixer) only while no word
// is in flight; the block does not enforce this. Physical and target values
// are read only once written, so no clearing pass is needed after reset.
// ---------------------------------------------------------------------------
module control_pickup_gate_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     func,
    input  logic [3:0]                     control_id,
    input  logic signed [2:0]              deck_index,
    input  logic [cpg_pkg::VALUE_BITS-1:0] control_value,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [cpg_pkg::TOL_BITS-1:0]   cfg_data,
    output logic                           done,
    output logic                           accepted,
    output logic                           state_changed,
    output logic                           retarget_notice,
    output logic                           pickup_active,
    output logic [cpg_pkg::COUNT_W-1:0]    pending_count
);

    logic          q_full;
    logic          q_empty;
    logic          push;
    cpg_pkg::cmd_t push_word;
    cpg_pkg::cmd_t pop_word;

    cpg_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .control_id    (control_id),
        .deck_index    (deck_index),
        .control_value (control_value),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_full        (q_full),
        .push          (push),
        .push_word     (push_word)
    );

    // back end never stalls, so the queue drains one word every cycle
    cpg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (!q_empty),
        .pop_word  (pop_word),
        .full      (q_full),
        .empty     (q_empty)
    );

    cpg_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (!q_empty),
        .cmd             (pop_word),
        .done            (done),
        .accepted        (accepted),
        .state_changed   (state_changed),
        .retarget_notice (retarget_notice),
        .pickup_active   (pickup_active),
        .pending_count   (pending_count)
    );

    // pending count never exceeds the slot count
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        pending_count <= cpg_pkg::COUNT_W'(cpg_pkg::NUM_SLOTS))
        else $error("pending count out of range");

    // a consumed move is never also passed through
    a_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        done && state_changed |-> !accepted)
        else $error("move both consumed and passed");

    // a result follows every word issued
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##3 done)
        else $error("missing result");

    // the pending count moves by at most one unless it drops to zero
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(done) |->
            pending_count == '0 ||
            pending_count == $past(pending_count) ||
            pending_count == $past(pending_count) + cpg_pkg::COUNT_W'(1) ||
            pending_count == $past(pending_count) - cpg_pkg::COUNT_W'(1))
        else $error("pending count jumped");

endmodule
